FILE: hw/rtl/column_frame_receiver_crc16_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the column frame receiver
// Shared concurrent checks, sampled on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef COLUMN_FRAME_RECEIVER_CRC16_UNIT_DEFINES_SVH
`define COLUMN_FRAME_RECEIVER_CRC16_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define CFR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define CFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/cfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_pkg
// Types, codes and the CRC-16/CCITT step for the column frame receiver.
// ----------------------------------------------------------------------------
package cfr_pkg;

    localparam int COLUMN_BYTES_DEF = 32;
    localparam int PAYLOAD_MAX_DEF  = 198;
    localparam int POS_W            = 16;
    localparam int CNT_W            = 6;

    localparam logic [1:0] KIND_COL     = 2'd0;
    localparam logic [1:0] KIND_TX      = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;
    localparam logic [1:0] KIND_STATUS  = 2'd3;

    localparam logic [2:0] STS_DATA_DONE   = 3'd0;
    localparam logic [2:0] STS_CONFIG_OK   = 3'd1;
    localparam logic [2:0] STS_BAD_START   = 3'd2;
    localparam logic [2:0] STS_HEADER_CRC  = 3'd3;
    localparam logic [2:0] STS_COLUMN_CRC  = 3'd4;
    localparam logic [2:0] STS_PAYLOAD_CRC = 3'd5;
    localparam logic [2:0] STS_TIMEOUT     = 3'd6;
    localparam logic [2:0] STS_TOO_LONG    = 3'd7;

    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [7:0]  CFG_MARK   = 8'h1A;
    localparam logic [7:0]  DATA_MARK  = 8'hDA;
    localparam logic [7:0]  READY_BYTE = 8'hEC;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PAYLOAD,
        PH_COLUMN
    } phase_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_STATUS,
        ACT_PAYLOAD,
        ACT_READY,
        ACT_COLUMN
    } act_t;

    typedef enum logic [2:0] {
        SRC_STATUS,
        SRC_PAYLOAD,
        SRC_READY,
        SRC_COL,
        SRC_ECHO_HI,
        SRC_ECHO_LO
    } src_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_STATUS,
        S_PAYLOAD,
        S_READY,
        S_COL,
        S_ECHO_HI,
        S_ECHO_LO
    } state_t;

    typedef struct packed {
        logic accept;
        logic eval;
        logic load;
        src_t src;
        logic last;
        logic cnt_inc;
    } cmd_t;

    typedef struct packed {
        act_t act;
        logic tail;
        logic can_load;
        logic ready_end;
        logic col_end;
    } dps_t;

    function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] x;
        x = crc[15:8] ^ b;
        x = x ^ {4'd0, x[7:4]};
        return {crc[7:0], 8'd0} ^ {x[3:0], 12'd0} ^ {3'd0, x, 5'd0} ^ {8'd0, x};
    endfunction

endpackage

FILE: hw/rtl/cfr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module cfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hw/rtl/cfr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_ctrl
// Sequencer: takes a request, triggers evaluation, then issues result loads.
// ----------------------------------------------------------------------------
module cfr_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_stall,
    input  cfr_pkg::dps_t dps,
    output cfr_pkg::cmd_t cmd
);
    import cfr_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                unique case (dps.act)
                    ACT_NONE:    state_next = S_IDLE;
                    ACT_STATUS:  state_next = S_STATUS;
                    ACT_PAYLOAD: state_next = S_PAYLOAD;
                    ACT_READY:   state_next = S_READY;
                    ACT_COLUMN:  state_next = S_COL;
                    default:     state_next = S_IDLE;
                endcase
            end
            S_STATUS, S_PAYLOAD:
            begin
                if (dps.can_load)
                begin
                    state_next = S_IDLE;
                end
            end
            S_READY:
            begin
                if (dps.can_load && dps.ready_end)
                begin
                    state_next = dps.tail ? S_STATUS : S_IDLE;
                end
            end
            S_COL:
            begin
                if (dps.can_load && dps.col_end)
                begin
                    state_next = S_ECHO_HI;
                end
            end
            S_ECHO_HI:
            begin
                if (dps.can_load)
                begin
                    state_next = S_ECHO_LO;
                end
            end
            S_ECHO_LO:
            begin
                if (dps.can_load)
                begin
                    state_next = dps.tail ? S_STATUS : S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd        = '0;
        cmd.src    = SRC_STATUS;
        item_stall = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.accept = item_valid;
            end
            S_EVAL:
            begin
                cmd.eval = 1'b1;
            end
            S_STATUS:
            begin
                cmd.load = dps.can_load;
                cmd.src  = SRC_STATUS;
                cmd.last = 1'b1;
            end
            S_PAYLOAD:
            begin
                cmd.load = dps.can_load;
                cmd.src  = SRC_PAYLOAD;
                cmd.last = 1'b1;
            end
            S_READY:
            begin
                cmd.load    = dps.can_load;
                cmd.src     = SRC_READY;
                cmd.last    = dps.ready_end && !dps.tail;
                cmd.cnt_inc = dps.can_load;
            end
            S_COL:
            begin
                cmd.load    = dps.can_load;
                cmd.src     = SRC_COL;
                cmd.cnt_inc = dps.can_load;
            end
            S_ECHO_HI:
            begin
                cmd.load = dps.can_load;
                cmd.src  = SRC_ECHO_HI;
            end
            S_ECHO_LO:
            begin
                cmd.load = dps.can_load;
                cmd.src  = SRC_ECHO_LO;
                cmd.last = !dps.tail;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: hw/rtl/cfr_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_dp
// Receiver state, CRC, column buffer and the result register.
// ----------------------------------------------------------------------------
module cfr_dp #(
    parameter int COLUMN_BYTES = cfr_pkg::COLUMN_BYTES_DEF,
    parameter int PAYLOAD_MAX  = cfr_pkg::PAYLOAD_MAX_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          op,
    input  logic [7:0]    rx_byte,
    input  cfr_pkg::cmd_t cmd,
    output cfr_pkg::dps_t dps,
    input  logic          result_stall,
    output logic          result_valid,
    output logic [1:0]    kind,
    output logic [7:0]    out_byte,
    output logic [15:0]   image_index,
    output logic [15:0]   column_index,
    output logic [5:0]    byte_offset,
    output logic [2:0]    status,
    output logic          last
);
    import cfr_pkg::*;

    localparam int AW = (COLUMN_BYTES > 1) ? $clog2(COLUMN_BYTES) : 1;
    localparam logic [POS_W-1:0] CB_POS  = POS_W'(COLUMN_BYTES);
    localparam logic [POS_W-1:0] PMAX    = POS_W'(PAYLOAD_MAX);
    localparam logic [CNT_W-1:0] CB_LAST = CNT_W'(COLUMN_BYTES - 1);
    localparam logic [CNT_W-1:0] RDY_LAST = CNT_W'(7);

    // request latch
    logic       op_reg;
    logic [7:0] byte_reg;

    // receiver state
    phase_t           phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      crc_reg, crc_next;
    logic [15:0]      hcrc_reg, hcrc_next;
    logic [7:0]       crc_hi_reg, crc_hi_next;
    logic [15:0]      imgs_reg, imgs_next;
    logic [15:0]      cols_reg, cols_next;
    logic [15:0]      img_cnt_reg, img_cnt_next;
    logic [15:0]      col_cnt_reg, col_cnt_next;
    logic [15:0]      plen_reg, plen_next;
    logic [7:0]       hdr_reg [7];

    // emission context
    logic [2:0]       sts_reg, sts_next;
    logic             tail_reg, tail_next;
    logic [15:0]      emit_img_reg;
    logic [15:0]      emit_col_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    act_t             act;
    logic             ram_we;
    logic [AW-1:0]    ram_raddr;
    logic [7:0]       ram_rdata;

    // evaluation helpers
    logic        is_cfg, is_data, hdr_done;
    logic [15:0] hdr_crc_full, got_crc, recv_crc, hdr_len;
    logic [15:0] col_inc, img_inc;
    logic        can_load;

    // result fields to load
    logic [1:0]  kind_next;
    logic [7:0]  out_byte_next;
    logic [15:0] image_index_next;
    logic [15:0] column_index_next;
    logic [5:0]  byte_offset_next;
    logic [2:0]  status_next;

    always_comb
    begin
        is_cfg   = (hdr_reg[0] == CFG_MARK) && (hdr_reg[1] == CFG_MARK) &&
                   (hdr_reg[2] == CFG_MARK) && (hdr_reg[3] == CFG_MARK);
        is_data  = (hdr_reg[0] == DATA_MARK) && (hdr_reg[1] == DATA_MARK);
        hdr_done = (pos_reg == POS_W'(7));
        hdr_crc_full = hcrc_reg;
        got_crc  = {hdr_reg[6], byte_reg};
        recv_crc = {crc_hi_reg, byte_reg};
        hdr_len  = {hdr_reg[4], hdr_reg[5]};
        col_inc  = col_cnt_reg + 16'd1;
        img_inc  = img_cnt_reg + 16'd1;
    end

    // one step of the receiver
    always_comb
    begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        crc_next     = crc_reg;
        hcrc_next    = hcrc_reg;
        crc_hi_next  = crc_hi_reg;
        imgs_next    = imgs_reg;
        cols_next    = cols_reg;
        img_cnt_next = img_cnt_reg;
        col_cnt_next = col_cnt_reg;
        plen_next    = plen_reg;
        sts_next     = sts_reg;
        tail_next    = tail_reg;
        act          = ACT_NONE;
        ram_we       = 1'b0;
        if (cmd.eval)
        begin
            tail_next = 1'b0;
            if (op_reg)
            begin
                if (!(phase_reg == PH_HEADER && pos_reg == '0))
                begin
                    phase_next = PH_HEADER;
                    pos_next   = '0;
                    crc_next   = CRC_INIT;
                    act        = ACT_STATUS;
                    sts_next   = STS_TIMEOUT;
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_PAYLOAD:
                    begin
                        if (pos_reg < plen_reg)
                        begin
                            crc_next = crc_add(crc_reg, byte_reg);
                            pos_next = pos_reg + POS_W'(1);
                            act      = ACT_PAYLOAD;
                        end
                        else if (pos_reg == plen_reg)
                        begin
                            crc_hi_next = byte_reg;
                            pos_next    = pos_reg + POS_W'(1);
                        end
                        else
                        begin
                            phase_next = PH_HEADER;
                            pos_next   = '0;
                            crc_next   = CRC_INIT;
                            act        = ACT_STATUS;
                            sts_next   = (crc_reg == recv_crc) ? STS_CONFIG_OK
                                                               : STS_PAYLOAD_CRC;
                        end
                    end
                    PH_COLUMN:
                    begin
                        if (pos_reg < CB_POS)
                        begin
                            ram_we   = 1'b1;
                            crc_next = crc_add(crc_reg, byte_reg);
                            pos_next = pos_reg + POS_W'(1);
                        end
                        else if (pos_reg == CB_POS)
                        begin
                            crc_hi_next = byte_reg;
                            pos_next    = pos_reg + POS_W'(1);
                        end
                        else if (crc_reg != recv_crc)
                        begin
                            phase_next = PH_HEADER;
                            pos_next   = '0;
                            crc_next   = CRC_INIT;
                            act        = ACT_STATUS;
                            sts_next   = STS_COLUMN_CRC;
                        end
                        else
                        begin
                            act          = ACT_COLUMN;
                            pos_next     = '0;
                            crc_next     = CRC_INIT;
                            col_cnt_next = col_inc;
                            sts_next     = STS_DATA_DONE;
                            if (col_inc >= cols_reg)
                            begin
                                col_cnt_next = '0;
                                img_cnt_next = img_inc;
                                if (img_inc >= imgs_reg)
                                begin
                                    phase_next = PH_HEADER;
                                    tail_next  = 1'b1;
                                end
                            end
                        end
                    end
                    default:
                    begin
                        // header collection; CRC runs over bytes 0 to 5
                        pos_next = pos_reg + POS_W'(1);
                        if (pos_reg < POS_W'(6))
                        begin
                            hcrc_next = crc_add((pos_reg == '0) ? CRC_INIT : hcrc_reg,
                                                byte_reg);
                        end
                        if (hdr_done)
                        begin
                            phase_next = PH_HEADER;
                            pos_next   = '0;
                            crc_next   = CRC_INIT;
                            if (!is_cfg && !is_data)
                            begin
                                act      = ACT_STATUS;
                                sts_next = STS_BAD_START;
                            end
                            else if (hdr_crc_full != got_crc)
                            begin
                                act      = ACT_STATUS;
                                sts_next = STS_HEADER_CRC;
                            end
                            else if (is_cfg)
                            begin
                                if (hdr_len > PMAX)
                                begin
                                    act      = ACT_STATUS;
                                    sts_next = STS_TOO_LONG;
                                end
                                else
                                begin
                                    plen_next  = hdr_len;
                                    phase_next = PH_PAYLOAD;
                                    act        = ACT_READY;
                                end
                            end
                            else
                            begin
                                imgs_next    = {hdr_reg[2], hdr_reg[3]};
                                cols_next    = hdr_len;
                                img_cnt_next = '0;
                                col_cnt_next = '0;
                                act          = ACT_READY;
                                sts_next     = STS_DATA_DONE;
                                if ({hdr_reg[2], hdr_reg[3]} == '0 || hdr_len == '0)
                                begin
                                    tail_next = 1'b1;
                                end
                                else
                                begin
                                    phase_next = PH_COLUMN;
                                end
                            end
                        end
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        if (cmd.eval)
        begin
            cnt_next = '0;
        end
        else if (cmd.cnt_inc)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else
        begin
            cnt_next = cnt_reg;
        end
        ram_raddr = (cnt_next < CNT_W'(COLUMN_BYTES)) ? cnt_next[AW-1:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEADER;
            pos_reg     <= '0;
            crc_reg     <= CRC_INIT;
            hcrc_reg    <= CRC_INIT;
            crc_hi_reg  <= '0;
            imgs_reg    <= '0;
            cols_reg    <= '0;
            img_cnt_reg <= '0;
            col_cnt_reg <= '0;
            plen_reg    <= '0;
            sts_reg     <= '0;
            tail_reg    <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            crc_reg     <= crc_next;
            hcrc_reg    <= hcrc_next;
            crc_hi_reg  <= crc_hi_next;
            imgs_reg    <= imgs_next;
            cols_reg    <= cols_next;
            img_cnt_reg <= img_cnt_next;
            col_cnt_reg <= col_cnt_next;
            plen_reg    <= plen_next;
            sts_reg     <= sts_next;
            tail_reg    <= tail_next;
            cnt_reg     <= cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg   <= op;
            byte_reg <= rx_byte;
        end
        if (cmd.eval && !op_reg && phase_reg == PH_HEADER && pos_reg < POS_W'(7))
        begin
            hdr_reg[pos_reg[2:0]] <= byte_reg;
        end
        if (cmd.eval)
        begin
            emit_img_reg <= img_cnt_reg;
            emit_col_reg <= col_cnt_reg;
        end
    end

    cfr_ram #(
        .WIDTH (8),
        .DEPTH (COLUMN_BYTES),
        .AW    (AW)
    ) u_col_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pos_reg[AW-1:0]),
        .wdata (byte_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // result register
    assign can_load = !result_valid || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid <= 1'b0;
        end
        else if (cmd.load)
        begin
            result_valid <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid <= 1'b0;
        end
    end

    // fields of the next result, by source
    always_comb
    begin
        kind_next         = KIND_STATUS;
        out_byte_next     = '0;
        image_index_next  = '0;
        column_index_next = '0;
        byte_offset_next  = '0;
        status_next       = '0;
        unique case (cmd.src)
            SRC_STATUS:
            begin
                kind_next   = KIND_STATUS;
                status_next = sts_reg;
            end
            SRC_PAYLOAD:
            begin
                kind_next     = KIND_PAYLOAD;
                out_byte_next = byte_reg;
            end
            SRC_READY:
            begin
                kind_next     = KIND_TX;
                out_byte_next = READY_BYTE;
            end
            SRC_COL:
            begin
                kind_next         = KIND_COL;
                out_byte_next     = ram_rdata;
                image_index_next  = emit_img_reg;
                column_index_next = emit_col_reg;
                byte_offset_next  = cnt_reg;
            end
            SRC_ECHO_HI:
            begin
                kind_next     = KIND_TX;
                out_byte_next = crc_hi_reg;
            end
            SRC_ECHO_LO:
            begin
                kind_next     = KIND_TX;
                out_byte_next = byte_reg;
            end
            default:
            begin
                kind_next = KIND_STATUS;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind         <= kind_next;
            out_byte     <= out_byte_next;
            image_index  <= image_index_next;
            column_index <= column_index_next;
            byte_offset  <= byte_offset_next;
            status       <= status_next;
            last         <= cmd.last;
        end
    end

    always_comb
    begin
        dps.act       = act;
        dps.tail      = tail_reg;
        dps.can_load  = can_load;
        dps.ready_end = (cnt_reg == RDY_LAST);
        dps.col_end   = (cnt_reg == CB_LAST);
    end

endmodule

FILE: hw/rtl/column_frame_receiver_crc16_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// column_frame_receiver_crc16_unit
// A request is latched on accept, evaluated in S_EVAL, then loads its results.
// No new request is taken until all its results are loaded; a good column gives
//   COLUMN_BYTES+2 results (one more, a status, if it ends the message),
//   read one a cycle from the column RAM while the result side does not stall.
// Reset: asynchronous, active low; returns to header collection, CRC 0xFFFF.
// ----------------------------------------------------------------------------
`include "column_frame_receiver_crc16_unit_defines.svh"

module column_frame_receiver_crc16_unit #(
    parameter int COLUMN_BYTES = cfr_pkg::COLUMN_BYTES_DEF,
    parameter int PAYLOAD_MAX  = cfr_pkg::PAYLOAD_MAX_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        op,
    input  logic [7:0]  rx_byte,
    // result channel
    output logic        result_valid,
    input  logic        result_stall,
    output logic [1:0]  kind,
    output logic [7:0]  out_byte,
    output logic [15:0] image_index,
    output logic [15:0] column_index,
    output logic [5:0]  byte_offset,
    output logic [2:0]  status,
    output logic        last
);
    import cfr_pkg::*;

    // controller <-> datapath
    cmd_t cmd;
    dps_t dps;

    // Controller: idle -> evaluate -> emit results one per free slot of the
    // output register. Request stall is high whenever it is not idle.
    cfr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .dps        (dps),
        .cmd        (cmd)
    );

    // Datapath: receiver phase/position, header and running CRC, column RAM,
    // and the result register that decouples the two channels.
    cfr_dp #(
        .COLUMN_BYTES (COLUMN_BYTES),
        .PAYLOAD_MAX  (PAYLOAD_MAX)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .rx_byte      (rx_byte),
        .cmd          (cmd),
        .dps          (dps),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .kind         (kind),
        .out_byte     (out_byte),
        .image_index  (image_index),
        .column_index (column_index),
        .byte_offset  (byte_offset),
        .status       (status),
        .last         (last)
    );

    // an accepted request always holds off the next one for evaluation
    `CFR_ASSERT_NEXT(a_busy_after_req, item_valid && !item_stall, item_stall,
                     "request accepted while evaluation pending")
    // only column bytes carry position information
    `CFR_ASSERT_SAME(a_index_zero, result_valid && kind != KIND_COL,
                     image_index == '0 && column_index == '0 && byte_offset == '0,
                     "position fields set on a non-column result")
    // status results carry no byte
    `CFR_ASSERT_SAME(a_status_byte, result_valid && kind == KIND_STATUS,
                     out_byte == '0, "status result with nonzero byte")

endmodule

FILE: tb/cfr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_checker
// Watches both channels of the column frame receiver, predicts the results of
// every accepted request and compares them in order against what comes out.
// ----------------------------------------------------------------------------
package cfr_tb_pkg;

    // bitwise CRC-16/CCITT step, poly 0x1021, MSB first
    function automatic logic [15:0] ccitt_step(input logic [15:0] c, input logic [7:0] d);
        logic [15:0] r;
        r = c ^ {d, 8'h00};
        for (int i = 0; i < 8; i++)
            r = r[15] ? ((r << 1) ^ 16'h1021) : (r << 1);
        return r;
    endfunction

endpackage

module cfr_checker
    import cfr_pkg::*;
    import cfr_tb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  logic        item_stall,
    input  logic        op,
    input  logic [7:0]  rx_byte,
    input  logic        result_valid,
    input  logic        result_stall,
    input  logic [1:0]  kind,
    input  logic [7:0]  out_byte,
    input  logic [15:0] image_index,
    input  logic [15:0] column_index,
    input  logic [5:0]  byte_offset,
    input  logic [2:0]  status,
    input  logic        last,
    output int          errors,
    output int          pending,
    output int          checked
);

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [15:0] img;
        logic [15:0] col;
        logic [5:0]  off;
        logic [2:0]  sts;
        logic        last;
    } rx_result_t;

    rx_result_t  want_q[$];

    // receiver model state
    phase_t      m_phase;
    logic [7:0]  m_hdr[8];
    logic [15:0] m_pos;
    logic [15:0] m_crc;
    logic [7:0]  m_crc_hi;
    logic [15:0] m_imgs, m_cols, m_img_cnt, m_col_cnt, m_plen;
    logic [7:0]  m_col_buf[COLUMN_BYTES_DEF];

    assign pending = want_q.size();

    task automatic push(input logic [1:0] k, input logic [7:0] d, input logic [15:0] img,
                        input logic [15:0] col, input logic [5:0] off, input logic [2:0] s);
        rx_result_t r;
        r = '{kind: k, data: d, img: img, col: col, off: off, sts: s, last: 1'b0};
        want_q.push_back(r);
    endtask

    task automatic back_to_header();
        m_phase = PH_HEADER;
        m_pos   = '0;
        m_crc   = CRC_INIT;
    endtask

    task automatic ready_burst();
        for (int i = 0; i < 8; i++)
            push(KIND_TX, READY_BYTE, '0, '0, '0, '0);
    endtask

    task automatic header_complete();
        logic [15:0] c;
        logic        cfg;
        logic [15:0] len;
        c   = CRC_INIT;
        cfg = (m_hdr[0] == CFG_MARK) && (m_hdr[1] == CFG_MARK) &&
              (m_hdr[2] == CFG_MARK) && (m_hdr[3] == CFG_MARK);
        for (int i = 0; i < 6; i++)
            c = ccitt_step(c, m_hdr[i]);
        back_to_header();
        if (!cfg && !(m_hdr[0] == DATA_MARK && m_hdr[1] == DATA_MARK))
            push(KIND_STATUS, '0, '0, '0, '0, STS_BAD_START);
        else if (c != {m_hdr[6], m_hdr[7]})
            push(KIND_STATUS, '0, '0, '0, '0, STS_HEADER_CRC);
        else if (cfg) begin
            len = {m_hdr[4], m_hdr[5]};
            if (len > PAYLOAD_MAX_DEF)
                push(KIND_STATUS, '0, '0, '0, '0, STS_TOO_LONG);
            else
            begin
                m_plen  = len;
                m_phase = PH_PAYLOAD;
                ready_burst();
            end
        end else
        begin
            m_imgs    = {m_hdr[2], m_hdr[3]};
            m_cols    = {m_hdr[4], m_hdr[5]};
            m_img_cnt = '0;
            m_col_cnt = '0;
            ready_burst();
            if (m_imgs == 0 || m_cols == 0)
                push(KIND_STATUS, '0, '0, '0, '0, STS_DATA_DONE);
            else
                m_phase = PH_COLUMN;
        end
    endtask

    task automatic predict_request(input logic o, input logic [7:0] b);
        int base;
        base = want_q.size();
        if (o) begin
            if (!(m_phase == PH_HEADER && m_pos == 0)) begin
                back_to_header();
                push(KIND_STATUS, '0, '0, '0, '0, STS_TIMEOUT);
            end
        end else if (m_phase == PH_PAYLOAD) begin
            if (m_pos < m_plen) begin
                m_crc = ccitt_step(m_crc, b);
                m_pos++;
                push(KIND_PAYLOAD, b, '0, '0, '0, '0);
            end else if (m_pos == m_plen) begin
                m_crc_hi = b;
                m_pos++;
            end else
            begin
                push(KIND_STATUS, '0, '0, '0, '0,
                     (m_crc == {m_crc_hi, b}) ? STS_CONFIG_OK : STS_PAYLOAD_CRC);
                back_to_header();
            end
        end else if (m_phase == PH_COLUMN) begin
            if (m_pos < COLUMN_BYTES_DEF) begin
                m_col_buf[m_pos] = b;
                m_crc = ccitt_step(m_crc, b);
                m_pos++;
            end else if (m_pos == COLUMN_BYTES_DEF) begin
                m_crc_hi = b;
                m_pos++;
            end else if (m_crc != {m_crc_hi, b}) begin
                back_to_header();
                push(KIND_STATUS, '0, '0, '0, '0, STS_COLUMN_CRC);
            end else
            begin
                for (int i = 0; i < COLUMN_BYTES_DEF; i++)
                    push(KIND_COL, m_col_buf[i], m_img_cnt, m_col_cnt, 6'(i), '0);
                push(KIND_TX, m_crc_hi, '0, '0, '0, '0);
                push(KIND_TX, b, '0, '0, '0, '0);
                m_pos = '0;
                m_crc = CRC_INIT;
                m_col_cnt++;
                if (m_col_cnt >= m_cols) begin
                    m_col_cnt = '0;
                    m_img_cnt++;
                    if (m_img_cnt >= m_imgs) begin
                        back_to_header();
                        push(KIND_STATUS, '0, '0, '0, '0, STS_DATA_DONE);
                    end
                end
            end
        end else
        begin
            m_hdr[m_pos[2:0]] = b;
            m_pos++;
            if (m_pos >= 8)
                header_complete();
        end
        if (want_q.size() > base)
            want_q[$].last = 1'b1;
    endtask

    task automatic compare_result();
        rx_result_t got, want;
        got = '{kind: kind, data: out_byte, img: image_index, col: column_index,
                off: byte_offset, sts: status, last: last};
        checked++;
        if (want_q.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("ERROR %0t: unexpected result %p", $realtime, got);
            return;
        end
        want = want_q.pop_front();
        if (got !== want) begin
            errors++;
            if (errors <= 10)
                $display("ERROR %0t: result %0d exp %p got %p", $realtime, checked, want, got);
        end
    endtask

    initial
    begin
        errors  = 0;
        checked = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            want_q.delete();
            back_to_header();
            m_crc_hi = '0;
            m_imgs = '0; m_cols = '0; m_img_cnt = '0; m_col_cnt = '0; m_plen = '0;
        end else
        begin
            // results first: none can stem from a request taken at this edge
            if (result_valid && !result_stall)
                compare_result();
            if (item_valid && !item_stall)
                predict_request(op, rx_byte);
        end
    end

endmodule

FILE: tb/tb_column_frame_receiver_crc16_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_column_frame_receiver_crc16_unit
// Drives framed byte streams (config and data messages, broken headers, bad
// CRCs, timeouts and noise) into the receiver under random idling on both
// sides; the checker beside it predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_column_frame_receiver_crc16_unit;
    import cfr_pkg::*;
    import cfr_tb_pkg::*;

    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_TIMEOUT = 1'b1;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    logic        op;
    logic [7:0]  rx_byte;
    logic        result_valid;
    logic        result_stall;
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic [15:0] image_index;
    logic [15:0] column_index;
    logic [5:0]  byte_offset;
    logic [2:0]  status;
    logic        last;

    int errors, pending, checked;
    int sent;          // requests accepted
    bit calm;          // no idling on either side while set
    bit hold_req;      // asks the result side for one long hold-off

    column_frame_receiver_crc16_unit uut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall), .op(op), .rx_byte(rx_byte),
        .result_valid(result_valid), .result_stall(result_stall),
        .kind(kind), .out_byte(out_byte), .image_index(image_index),
        .column_index(column_index), .byte_offset(byte_offset),
        .status(status), .last(last)
    );

    cfr_checker chk (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall), .op(op), .rx_byte(rx_byte),
        .result_valid(result_valid), .result_stall(result_stall),
        .kind(kind), .out_byte(out_byte), .image_index(image_index),
        .column_index(column_index), .byte_offset(byte_offset),
        .status(status), .last(last),
        .errors(errors), .pending(pending), .checked(checked)
    );

    // 8 ns clock
    always
    begin
        clk = 1'b0; #4;
        clk = 1'b1; #4;
    end

    // Result side: a random stall before each result, plus one long hold-off
    // on request. Stall is only ever touched once per edge.
    initial
    begin
        int w;
        result_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req) begin
                result_stall <= 1'b1;
                repeat (300) @(posedge clk);
                hold_req = 1'b0;
            end
            w = calm ? 0 : $urandom_range(0, 3);
            if (w > 0) begin
                result_stall <= 1'b1;
                repeat (w) @(posedge clk);
            end
            result_stall <= 1'b0;
            @(posedge clk);
            // values read right after the edge are the ones the edge sampled
            while (!result_valid) @(posedge clk);
        end
    end

    // One request: optional gap, then hold valid until taken.
    task automatic send(input logic o, input logic [7:0] b);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        op         <= o;
        rx_byte    <= b;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        sent++;
    endtask

    // Sender goes quiet until every predicted result has been seen.
    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Six header bytes plus their CRC; bad flips one CRC bit.
    task automatic send_header(input logic [7:0] b0, b1, b2, b3, b4, b5, input bit bad);
        logic [7:0]  h[6];
        logic [15:0] c;
        h = '{b0, b1, b2, b3, b4, b5};
        c = CRC_INIT;
        foreach (h[i])
        begin
            c = ccitt_step(c, h[i]);
            send(OP_BYTE, h[i]);
        end
        if (bad)
            c ^= 16'(1 << $urandom_range(0, 15));
        send(OP_BYTE, c[15:8]);
        send(OP_BYTE, c[7:0]);
    endtask

    // Config message; payload CRC corrupted when bad.
    task automatic config_msg(input logic [15:0] len, input bit bad);
        logic [15:0] c;
        logic [7:0]  d;
        c = CRC_INIT;
        send_header(CFG_MARK, CFG_MARK, CFG_MARK, CFG_MARK, len[15:8], len[7:0], 1'b0);
        if (len > PAYLOAD_MAX_DEF)
            return;
        for (int i = 0; i < len; i++)
        begin
            d = $urandom;
            c = ccitt_step(c, d);
            send(OP_BYTE, d);
        end
        if (bad)
            c ^= 16'(1 << $urandom_range(0, 15));
        send(OP_BYTE, c[15:8]);
        send(OP_BYTE, c[7:0]);
    endtask

    // Data message. ncol columns are sent (ncol may stop short of the
    // header's count; the caller then ends it with a timeout). Column
    // bad_col, if any, carries a wrong CRC and ends the message.
    task automatic data_msg(input logic [15:0] imgs, cols, input int ncol, input int bad_col);
        logic [15:0] c;
        logic [7:0]  d;
        send_header(DATA_MARK, DATA_MARK, imgs[15:8], imgs[7:0], cols[15:8], cols[7:0], 1'b0);
        for (int k = 0; k < ncol; k++)
        begin
            c = CRC_INIT;
            for (int i = 0; i < COLUMN_BYTES_DEF; i++)
            begin
                d = $urandom;
                c = ccitt_step(c, d);
                send(OP_BYTE, d);
            end
            if (k == bad_col)
                c ^= 16'(1 << $urandom_range(0, 15));
            send(OP_BYTE, c[15:8]);
            send(OP_BYTE, c[7:0]);
            if (k == bad_col)
                return;
        end
    endtask

    // Limit: far above the slowest legal run.
    initial
    begin
        #40ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int r, n;
        logic [15:0] a, b;
        item_valid <= 1'b0;
        op         <= OP_BYTE;
        rx_byte    <= '0;
        calm       = 1'b0;
        hold_req   = 1'b0;
        sent       = 0;
        rst_n      = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part ----
        send(OP_TIMEOUT, 8'hFF);                                 // idle gap: no result
        send_header(8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 1'b0);  // bad start
        send_header(DATA_MARK, DATA_MARK, 8'h00, 8'h01, 8'h00, 8'h01, 1'b1); // header crc
        config_msg(16'd199, 1'b0);                               // too long
        config_msg(16'hFFFF, 1'b0);                              // too long, extreme
        config_msg(16'd0, 1'b0);                                 // empty payload
        config_msg(16'd3, 1'b1);                                 // payload crc wrong
        data_msg(16'd0, 16'hFFFF, 0, -1);                        // empty: zero images
        data_msg(16'hFFFF, 16'd0, 0, -1);                        // empty: zero columns
        data_msg(16'd1, 16'd1, 1, -1);                           // one good column
        data_msg(16'd1, 16'd2, 2, 0);                            // column crc wrong
        send(OP_BYTE, 8'h12);                                    // timeout mid header
        send(OP_TIMEOUT, 8'h00);
        drain();

        // ---- random part ----
        while (sent < 450)
        begin
            calm = ($urandom_range(0, 9) == 0);
            r = $urandom_range(0, 99);
            if (sent > 200 && sent < 260 && !hold_req) begin
                // long hold-off on results while requests keep coming
                calm     = 1'b1;
                hold_req = 1'b1;
                data_msg(16'd1, 16'd3, 3, -1);
                calm = 1'b0;
                drain();
            end else if (r < 35) begin
                a = $urandom_range(1, 2);
                b = (a == 2) ? 16'd1 : 16'($urandom_range(1, 2));
                n = a * b;
                data_msg(a, b, n, ($urandom_range(0, 4) == 0) ? $urandom_range(0, n - 1) : -1);
            end else if (r < 45) begin
                // huge counts, cut short by a timeout
                a = $urandom;
                b = $urandom;
                data_msg(a | 16'h8000, b | 16'h8000, $urandom_range(0, 1), -1);
                send(OP_TIMEOUT, $urandom);
            end else if (r < 68) begin
                a = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(195, 202))
                                               : 16'($urandom_range(0, 12));
                config_msg(a, $urandom_range(0, 4) == 0);
            end else if (r < 76) begin
                // complete config message, then a timeout that finds the header idle
                config_msg(16'($urandom_range(5, 30)), 1'b0);
                send(OP_TIMEOUT, 8'h00);
            end else if (r < 86) begin
                send_header($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                            $urandom_range(0, 1));
            end else
            begin
                n = $urandom_range(1, 6);
                repeat (n) send($urandom_range(0, 1), $urandom);
                send(OP_TIMEOUT, $urandom);
            end
            if (sent > 320 && sent < 360)
                drain();
        end

        calm = 1'b0;
        drain();
        repeat (20) @(posedge clk);

        $display("Summary: %0d requests driven, %0d results checked across config,",
                 sent, checked);
        $display("  data, broken-header, CRC-error, timeout and noise traffic.");
        if (errors == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
